>>> design/mlte_pkg.sv
// shared types and codes for the list table engine
package mlte_pkg;

  localparam logic [2:0] FN_CREATE = 3'd0;
  localparam logic [2:0] FN_APPEND = 3'd1;
  localparam logic [2:0] FN_DROP   = 3'd2;
  localparam logic [2:0] FN_DELETE = 3'd3;
  localparam logic [2:0] FN_RESIZE = 3'd4;
  localparam logic [2:0] FN_COUNT  = 3'd5;
  localparam logic [2:0] FN_READ   = 3'd6;
  localparam logic [2:0] FN_SORTED = 3'd7;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BAD_SLOT  = 4'd1;
  localparam logic [3:0] ST_EXISTS    = 4'd2;
  localparam logic [3:0] ST_BAD_SIZE  = 4'd3;
  localparam logic [3:0] ST_FULL      = 4'd4;
  localparam logic [3:0] ST_NO_LIST   = 4'd5;
  localparam logic [3:0] ST_EMPTY     = 4'd6;
  localparam logic [3:0] ST_NOT_FOUND = 4'd7;
  localparam logic [3:0] ST_NO_MEM    = 4'd8;

  localparam logic [31:0] SORT_PAD = 32'h7fff_ffff;

  typedef struct packed {
    logic latch;
    logic single;
    logic k_clr;
    logic k_inc;
    logic mem_rd;
    logic rd_plus1;
    logic shift_wr;
    logic del_done;
    logic not_found;
    logic ld_shift;
    logic sort_step;
    logic emit_elem;
  } cmd_t;

  typedef struct packed {
    logic chk_ok;
    logic is_delete;
    logic is_read;
    logic is_sorted;
    logic match;
    logic k_last_n;
    logic k_last_max;
  } stat_t;

endpackage

>>> design/mlte_ctrl.sv
// controller state machine sequencing each request
module mlte_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mlte_pkg::stat_t st,
  output mlte_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_SCAN_CHK, S_SH_RD, S_SH_WR,
    S_LD_RD, S_LD_WR, S_SORT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!st.chk_ok || !(st.is_delete || st.is_read)) begin
          cmd.single = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.k_clr = 1'b1;
          state_nxt = st.is_delete ? S_SCAN : S_LD_RD;
        end
      end
      S_SCAN: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (st.match) begin
          state_nxt = S_SH_RD;
        end else if (st.k_last_n) begin
          cmd.not_found = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SH_RD: begin
        if (st.k_last_n) begin
          cmd.del_done = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.rd_plus1 = 1'b1;
          state_nxt    = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.k_inc    = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_LD_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd.ld_shift = 1'b1;
        if (st.k_last_max) begin
          cmd.k_clr = 1'b1;
          state_nxt = st.is_sorted ? S_SORT : S_EMIT;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_LD_RD;
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (st.k_last_max) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.emit_elem = 1'b1;
        cmd.k_inc     = 1'b1;
        if (st.k_last_n) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> design/mlte_dp.sv
// datapath: list tables, value memory, read-out buffer and result registers
module mlte_dp #(
  parameter int NUM_LISTS = 10,
  parameter int MAX_LEN   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mlte_pkg::cmd_t     cmd,
  output mlte_pkg::stat_t    st,
  input  logic [2:0]         in_func,
  input  logic [3:0]         in_slot,
  input  logic signed [31:0] in_item_value,
  input  logic signed [6:0]  in_size_or_delta,
  output logic               out_valid,
  output logic [3:0]         out_status,
  output logic signed [31:0] out_data_value,
  output logic [4:0]         out_element_count,
  output logic               out_last_result
);

  localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int NW    = ((CW > 7) ? CW : 7) + 1;
  localparam int DEPTH = NUM_LISTS * MAX_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [2:0]         func_r;
  logic [3:0]         slot_r;
  logic signed [31:0] val_r;
  logic signed [6:0]  sd_r;

  logic              created_r [NUM_LISTS];
  logic [CW-1:0]     fill_r    [NUM_LISTS];
  logic [CW-1:0]     cap_r     [NUM_LISTS];
  logic [31:0]       mem       [DEPTH];
  logic [31:0]       rdata_r;
  logic signed [31:0] buf_r    [MAX_LEN];
  logic signed [31:0] buf_nxt  [MAX_LEN];
  logic [CW-1:0]     k_r;

  logic               slot_ok, created, is_delete, is_read;
  logic [LW-1:0]      li;
  logic [CW-1:0]      n, cap;
  logic signed [NW-1:0] ns;
  logic [3:0]         chk;
  logic [AW-1:0]      base, rd_addr, wr_addr;
  logic               we;
  logic [31:0]        wd;

  logic               ov_r, last_r;
  logic [3:0]         stat_r;
  logic signed [31:0] data_r;
  logic [4:0]         cnt_r;

  assign slot_ok = (slot_r != 4'd0) && (5'(slot_r) <= 5'(NUM_LISTS));
  assign li      = slot_ok ? LW'(4'(slot_r - 4'd1)) : '0;
  assign created = created_r[li];
  assign n       = fill_r[li];
  assign cap     = cap_r[li];
  assign ns      = $signed(NW'(cap)) + NW'(sd_r);

  always_comb begin
    chk = mlte_pkg::ST_OK;
    if (!slot_ok) begin
      chk = mlte_pkg::ST_BAD_SLOT;
    end else begin
      case (func_r)
        mlte_pkg::FN_CREATE: begin
          if (created) chk = mlte_pkg::ST_EXISTS;
          else if (sd_r < 7'sd1) chk = mlte_pkg::ST_BAD_SIZE;
          else if (32'(sd_r) > MAX_LEN) chk = mlte_pkg::ST_NO_MEM;
        end
        mlte_pkg::FN_APPEND: begin
          if (!created) chk = mlte_pkg::ST_NO_LIST;
          else if (n >= cap) chk = mlte_pkg::ST_FULL;
        end
        mlte_pkg::FN_RESIZE: begin
          if (ns < $signed(NW'(1))) chk = mlte_pkg::ST_BAD_SIZE;
          else if (!created) chk = mlte_pkg::ST_NO_LIST;
          else if (32'(ns) > MAX_LEN) chk = mlte_pkg::ST_NO_MEM;
        end
        default: begin
          if (!created) chk = mlte_pkg::ST_NO_LIST;
          else if (n == '0) chk = mlte_pkg::ST_EMPTY;
        end
      endcase
    end
  end

  assign is_delete = (func_r == mlte_pkg::FN_DELETE);
  assign is_read   = (func_r == mlte_pkg::FN_READ) || (func_r == mlte_pkg::FN_SORTED);

  assign st.chk_ok     = (chk == mlte_pkg::ST_OK);
  assign st.is_delete  = is_delete;
  assign st.is_read    = is_read;
  assign st.is_sorted  = (func_r == mlte_pkg::FN_SORTED);
  assign st.match      = (rdata_r == val_r);
  assign st.k_last_n   = ((CW + 1)'(k_r) + (CW + 1)'(1)) >= (CW + 1)'(n);
  assign st.k_last_max = (32'(k_r) == MAX_LEN - 1);

  // memory addressing
  assign base    = AW'(li * MAX_LEN);
  assign rd_addr = base + AW'(k_r) + AW'(cmd.rd_plus1);
  assign wr_addr = cmd.shift_wr ? base + AW'(k_r) : base + AW'(n);
  assign we      = cmd.shift_wr ||
                   (cmd.single && st.chk_ok && func_r == mlte_pkg::FN_APPEND);
  assign wd      = cmd.shift_wr ? rdata_r : val_r;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wd;
    if (cmd.mem_rd) rdata_r <= mem[rd_addr];
  end

  // read-out buffer: shift load, odd-even transposition sort, shift out
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) buf_nxt[i] = buf_r[i];
    if (cmd.ld_shift || cmd.emit_elem) begin
      for (int i = 0; i < MAX_LEN - 1; i++) buf_nxt[i] = buf_r[i + 1];
      if (cmd.ld_shift)
        buf_nxt[MAX_LEN - 1] = (k_r < n) ? $signed(rdata_r) : $signed(mlte_pkg::SORT_PAD);
    end else if (cmd.sort_step) begin
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        if ((i % 2) == int'(k_r[0]) && buf_r[i] > buf_r[i + 1]) begin
          buf_nxt[i]     = buf_r[i + 1];
          buf_nxt[i + 1] = buf_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LEN; i++) buf_r[i] <= buf_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      slot_r <= in_slot;
      val_r  <= in_item_value;
      sd_r   <= in_size_or_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + CW'(1);
    end
  end

  // list tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        created_r[i] <= 1'b0;
        fill_r[i]    <= '0;
        cap_r[i]     <= '0;
      end
    end else if (cmd.del_done) begin
      fill_r[li] <= n - CW'(1);
    end else if (cmd.single && st.chk_ok) begin
      case (func_r)
        mlte_pkg::FN_CREATE: begin
          created_r[li] <= 1'b1;
          cap_r[li]     <= CW'(sd_r);
          fill_r[li]    <= '0;
        end
        mlte_pkg::FN_APPEND: fill_r[li] <= n + CW'(1);
        mlte_pkg::FN_DROP:   fill_r[li] <= n - CW'(1);
        mlte_pkg::FN_RESIZE: begin
          cap_r[li] <= CW'(ns);
          if ($signed(NW'(n)) > ns) fill_r[li] <= CW'(ns);
        end
        default: ;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cmd.single || cmd.del_done || cmd.not_found || cmd.emit_elem;
    end
    if (cmd.single) begin
      stat_r <= chk;
      data_r <= '0;
      cnt_r  <= (st.chk_ok && func_r == mlte_pkg::FN_COUNT) ? 5'(n) : 5'd0;
      last_r <= 1'b1;
    end else if (cmd.del_done || cmd.not_found) begin
      stat_r <= cmd.not_found ? mlte_pkg::ST_NOT_FOUND : mlte_pkg::ST_OK;
      data_r <= '0;
      cnt_r  <= 5'd0;
      last_r <= 1'b1;
    end else if (cmd.emit_elem) begin
      stat_r <= mlte_pkg::ST_OK;
      data_r <= buf_r[0];
      cnt_r  <= 5'd0;
      last_r <= st.k_last_n;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = stat_r;
  assign out_data_value    = data_r;
  assign out_element_count = cnt_r;
  assign out_last_result   = last_r;

endmodule

>>> design/multi_list_table_engine_top.sv
// Bank of NUM_LISTS bounded lists of 32-bit values, one operation per request.
// A request is taken when start is high and busy low; results come one per
// cycle on out_valid and cannot be held off. Create, append, drop, resize,
// count and every request that fails its checks give a single result.
// Delete by value walks the list through the value memory's single read port:
// it compares each entry in turn, then moves each later entry down one place.
// Read and sorted read copy the whole row of MAX_LEN entries into a register
// buffer, sorted read adds MAX_LEN odd-even sort rounds, then one result per
// element follows.
module multi_list_table_engine_top #(
  parameter int NUM_LISTS = 10,
  parameter int MAX_LEN   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_func,
  input  logic [3:0]         in_slot,
  input  logic signed [31:0] in_item_value,
  input  logic signed [6:0]  in_size_or_delta,
  output logic               out_valid,
  output logic [3:0]         out_status,
  output logic signed [31:0] out_data_value,
  output logic [4:0]         out_element_count,
  output logic               out_last_result
);

  mlte_pkg::cmd_t  cmd;
  mlte_pkg::stat_t st;

  mlte_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  mlte_dp #(
    .NUM_LISTS (NUM_LISTS),
    .MAX_LEN   (MAX_LEN)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_func           (in_func),
    .in_slot           (in_slot),
    .in_item_value     (in_item_value),
    .in_size_or_delta  (in_size_or_delta),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_data_value    (out_data_value),
    .out_element_count (out_element_count),
    .out_last_result   (out_last_result)
  );

  // a read-out streams without gaps
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> out_valid)
    else $error("read-out stream broken");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mlte_pkg::ST_OK |-> out_last_result)
    else $error("error result not final");

  a_cnt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_count != 5'd0 |-> out_status == mlte_pkg::ST_OK)
    else $error("count with error status");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

endmodule

>>> tb/testbench.sv
// self-checking testbench for the list table engine
`timescale 1ns / 1ps

module testbench;

  localparam int NLISTS   = 10;
  localparam int LIST_MAX = 16;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] data_value;
    logic [4:0]  element_count;
    logic        last_result;
  } result_t;

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [31:0] value;
    logic [6:0]  size;
    bit          typed;
    logic [3:0]  status;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_func = '0;
  logic [3:0] in_slot = '0;
  logic signed [31:0] in_item_value = '0;
  logic signed [6:0] in_size_or_delta = '0;
  logic out_valid;
  logic [3:0] out_status;
  logic signed [31:0] out_data_value;
  logic [4:0] out_element_count;
  logic out_last_result;

  multi_list_table_engine_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_slot(in_slot), .in_item_value(in_item_value),
    .in_size_or_delta(in_size_or_delta), .out_valid(out_valid),
    .out_status(out_status), .out_data_value(out_data_value),
    .out_element_count(out_element_count), .out_last_result(out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the list bank
  logic [31:0] list_words [NLISTS][LIST_MAX];
  int unsigned list_fill [NLISTS];
  int unsigned list_cap [NLISTS];
  bit list_made [NLISTS];

  result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int idle_pct = 26;

  function automatic result_t mk(logic [3:0] st, logic [31:0] d, logic [4:0] c, logic l);
    result_t r;
    r.status = st; r.data_value = d; r.element_count = c; r.last_result = l;
    return r;
  endfunction

  // apply one request to the shadow bank and queue what it produces
  function automatic void predict_request(logic [2:0] fn, logic [3:0] sl,
                                          logic [31:0] v, logic [6:0] sd_raw);
    int li, n, i, j, ns, sd;
    logic [31:0] buff [LIST_MAX];
    logic [31:0] t;
    sd = $signed(sd_raw);
    if (sl < 1 || sl > NLISTS) begin
      expected_results.push_back(mk(mlte_pkg::ST_BAD_SLOT, 0, 0, 1));
      return;
    end
    li = sl - 1;
    n = list_fill[li];
    if (fn == mlte_pkg::FN_RESIZE) begin
      ns = int'(list_cap[li]) + sd;
      if (ns < 1) expected_results.push_back(mk(mlte_pkg::ST_BAD_SIZE, 0, 0, 1));
      else if (!list_made[li]) expected_results.push_back(mk(mlte_pkg::ST_NO_LIST, 0, 0, 1));
      else if (ns > LIST_MAX) expected_results.push_back(mk(mlte_pkg::ST_NO_MEM, 0, 0, 1));
      else begin
        list_cap[li] = ns;
        if (n > ns) list_fill[li] = ns;
        expected_results.push_back(mk(mlte_pkg::ST_OK, 0, 0, 1));
      end
      return;
    end
    if (fn == mlte_pkg::FN_CREATE) begin
      if (list_made[li]) expected_results.push_back(mk(mlte_pkg::ST_EXISTS, 0, 0, 1));
      else if (sd < 1) expected_results.push_back(mk(mlte_pkg::ST_BAD_SIZE, 0, 0, 1));
      else if (sd > LIST_MAX) expected_results.push_back(mk(mlte_pkg::ST_NO_MEM, 0, 0, 1));
      else begin
        list_made[li] = 1; list_cap[li] = sd; list_fill[li] = 0;
        expected_results.push_back(mk(mlte_pkg::ST_OK, 0, 0, 1));
      end
      return;
    end
    if (!list_made[li]) begin
      expected_results.push_back(mk(mlte_pkg::ST_NO_LIST, 0, 0, 1));
      return;
    end
    if (fn == mlte_pkg::FN_APPEND) begin
      if (n >= list_cap[li]) expected_results.push_back(mk(mlte_pkg::ST_FULL, 0, 0, 1));
      else begin
        list_words[li][n] = v; list_fill[li] = n + 1;
        expected_results.push_back(mk(mlte_pkg::ST_OK, 0, 0, 1));
      end
      return;
    end
    if (n == 0) begin
      expected_results.push_back(mk(mlte_pkg::ST_EMPTY, 0, 0, 1));
      return;
    end
    case (fn)
      mlte_pkg::FN_DROP: begin
        list_fill[li] = n - 1;
        expected_results.push_back(mk(mlte_pkg::ST_OK, 0, 0, 1));
      end
      mlte_pkg::FN_DELETE: begin
        for (i = 0; i < n && list_words[li][i] != v; i++) ;
        if (i >= n) expected_results.push_back(mk(mlte_pkg::ST_NOT_FOUND, 0, 0, 1));
        else begin
          for (; i + 1 < n; i++) list_words[li][i] = list_words[li][i+1];
          list_fill[li] = n - 1;
          expected_results.push_back(mk(mlte_pkg::ST_OK, 0, 0, 1));
        end
      end
      mlte_pkg::FN_COUNT: expected_results.push_back(mk(mlte_pkg::ST_OK, 0, n[4:0], 1));
      default: begin
        for (i = 0; i < n; i++) buff[i] = list_words[li][i];
        if (fn == mlte_pkg::FN_SORTED) begin
          for (i = 1; i < n; i++) begin
            t = buff[i];
            j = i;
            while (j > 0 && $signed(buff[j-1]) > $signed(t)) begin
              buff[j] = buff[j-1];
              j--;
            end
            buff[j] = t;
          end
        end
        for (i = 0; i < n; i++)
          expected_results.push_back(mk(mlte_pkg::ST_OK, buff[i], 0, i == n - 1));
      end
    endcase
  endfunction

  // result checker; the block cannot stall results so every strobe is taken
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid) begin
      got = mk(out_status, out_data_value, out_element_count, out_last_result);
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: got %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
        if (got.data_value !== want.data_value)
          $display("%0t data_value: expected %h actual %h", $time, want.data_value,
                   got.data_value);
        if (got.element_count !== want.element_count)
          $display("%0t element_count: expected %0d actual %0d", $time,
                   want.element_count, got.element_count);
        if (got.last_result !== want.last_result)
          $display("%0t last_result: expected %0d actual %0d", $time,
                   want.last_result, got.last_result);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog on cycles without any request or result accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // start stays high from one request to the next unless the sender idles
  task automatic send_request(logic [2:0] fn, logic [3:0] sl, logic [31:0] v, logic [6:0] sd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn; in_slot <= sl; in_item_value <= v; in_size_or_delta <= sd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(fn, sl, v, sd);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  row_t dir_rows[$];

  function automatic void add_row(logic [2:0] f, logic [3:0] s, logic [31:0] v,
                                  logic [6:0] z, bit ty = 0,
                                  logic [3:0] st = mlte_pkg::ST_OK);
    row_t r;
    r.func = f; r.slot = s; r.value = v; r.size = z; r.typed = ty; r.status = st;
    dir_rows.push_back(r);
  endfunction

  initial begin
    int k, fn, sl;
    logic [6:0] sz;
    add_row(mlte_pkg::FN_CREATE, 0, 0, 1, 1, mlte_pkg::ST_BAD_SLOT);
    add_row(mlte_pkg::FN_READ, 15, 32'hffff_ffff, 7'h7f, 1, mlte_pkg::ST_BAD_SLOT);
    add_row(mlte_pkg::FN_APPEND, 1, 5, 0, 1, mlte_pkg::ST_NO_LIST);
    add_row(mlte_pkg::FN_RESIZE, 1, 0, 7'h60, 1, mlte_pkg::ST_BAD_SIZE);
    add_row(mlte_pkg::FN_RESIZE, 2, 0, 4, 1, mlte_pkg::ST_NO_LIST);
    add_row(mlte_pkg::FN_CREATE, 1, 0, 0, 1, mlte_pkg::ST_BAD_SIZE);
    add_row(mlte_pkg::FN_CREATE, 1, 0, 7'h60, 1, mlte_pkg::ST_BAD_SIZE);
    add_row(mlte_pkg::FN_CREATE, 1, 0, 17, 1, mlte_pkg::ST_NO_MEM);
    add_row(mlte_pkg::FN_CREATE, 1, 0, 3, 1, mlte_pkg::ST_OK);
    add_row(mlte_pkg::FN_CREATE, 1, 0, 3, 1, mlte_pkg::ST_EXISTS);
    add_row(mlte_pkg::FN_COUNT, 1, 0, 0, 1, mlte_pkg::ST_EMPTY);
    add_row(mlte_pkg::FN_READ, 1, 0, 0, 1, mlte_pkg::ST_EMPTY);
    add_row(mlte_pkg::FN_DROP, 1, 0, 0, 1, mlte_pkg::ST_EMPTY);
    add_row(mlte_pkg::FN_DELETE, 1, 0, 0, 1, mlte_pkg::ST_EMPTY);
    add_row(mlte_pkg::FN_APPEND, 1, 32'h7fff_ffff, 0);
    add_row(mlte_pkg::FN_APPEND, 1, 32'h8000_0000, 0);
    add_row(mlte_pkg::FN_APPEND, 1, 32'h0000_0000, 0);
    add_row(mlte_pkg::FN_APPEND, 1, 9, 0, 1, mlte_pkg::ST_FULL);
    add_row(mlte_pkg::FN_SORTED, 1, 0, 0);
    add_row(mlte_pkg::FN_DELETE, 1, 1, 0, 1, mlte_pkg::ST_NOT_FOUND);
    add_row(mlte_pkg::FN_DELETE, 1, 32'h7fff_ffff, 0);
    add_row(mlte_pkg::FN_RESIZE, 1, 0, 7'h7f);
    add_row(mlte_pkg::FN_RESIZE, 1, 0, 7'h40, 1, mlte_pkg::ST_BAD_SIZE);
    add_row(mlte_pkg::FN_RESIZE, 1, 0, 32, 1, mlte_pkg::ST_NO_MEM);
    add_row(mlte_pkg::FN_CREATE, 10, 0, 16, 1, mlte_pkg::ST_OK);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[r]) begin
      send_request(dir_rows[r].func, dir_rows[r].slot, dir_rows[r].value, dir_rows[r].size);
      if (dir_rows[r].typed && expected_results[$].status !== dir_rows[r].status) begin
        $display("%0t row %0d: expected status %0d actual prediction %0d", $time, r,
                 dir_rows[r].status, expected_results[$].status);
        errors++;
      end
    end
    // random part: mostly valid slots, append-heavy so lists fill and sort deeply
    for (k = 0; k < 370; k++) begin
      idle_pct = (k >= 120 && k < 200) ? 0 : 26;
      sl = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, NLISTS);
      case ($urandom_range(19))
        0, 1: fn = mlte_pkg::FN_CREATE;
        2, 3, 4, 5, 6, 7: fn = mlte_pkg::FN_APPEND;
        8: fn = mlte_pkg::FN_DROP;
        9, 10: fn = mlte_pkg::FN_DELETE;
        11, 12: fn = mlte_pkg::FN_RESIZE;
        13: fn = mlte_pkg::FN_COUNT;
        14, 15: fn = mlte_pkg::FN_READ;
        default: fn = mlte_pkg::FN_SORTED;
      endcase
      if (fn == mlte_pkg::FN_CREATE)
        sz = ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(1, 16));
      else if (fn == mlte_pkg::FN_RESIZE)
        sz = ($urandom_range(4) == 0) ? 7'($urandom)
                                      : 7'($signed($urandom_range(8)) - 4);
      else sz = 7'($urandom);
      if (fn == mlte_pkg::FN_DELETE && sl >= 1 && sl <= NLISTS && list_fill[sl-1] > 0 &&
          $urandom_range(3) != 0)
        send_request(3'(fn), 4'(sl),
                     list_words[sl-1][$urandom_range(list_fill[sl-1] - 1)], sz);
      else
        send_request(3'(fn), 4'(sl), pick_value(), sz);
    end
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
